### sv/cfn_pkg.sv
// ============================================================================
// cfn_pkg: shared types and tables for the cube face tile neighbor finder
// Item structs, slot and edge codes, face fold and quarter mask tables.
// ============================================================================
`default_nettype none

package cfn_pkg;

    // Field widths fixed by the channel definition
    localparam int unsigned FACE_W  = 3;
    localparam int unsigned LEVEL_W = 5;
    localparam int unsigned POS_W   = 20;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned MASK_W  = 4;

    // Face codes
    localparam logic [FACE_W-1:0] FACE_BACK = 3'd5;

    // Neighbor slots, u + 3v
    localparam logic [SLOT_W-1:0] FIRST_SLOT  = 4'd0;
    localparam logic [SLOT_W-1:0] CENTER_SLOT = 4'd4;
    localparam logic [SLOT_W-1:0] LAST_SLOT   = 4'd8;

    // Column and row codes inside the 3x3 block
    localparam logic [1:0] COL_LEFT   = 2'd0;
    localparam logic [1:0] COL_MID    = 2'd1;
    localparam logic [1:0] COL_RIGHT  = 2'd2;
    localparam logic [1:0] ROW_BOTTOM = 2'd0;
    localparam logic [1:0] ROW_MID    = 2'd1;
    localparam logic [1:0] ROW_TOP    = 2'd2;

    // Quarter masks covered by the child tile, before inversion
    localparam logic [MASK_W-1:0] MASK_FULL  = 4'd15;
    localparam logic [MASK_W-1:0] MASK_NONE  = 4'd0;
    localparam logic [MASK_W-1:0] MASK_SIDE  = 4'd10;
    localparam logic [MASK_W-1:0] MASK_VERT  = 4'd12;
    localparam logic [MASK_W-1:0] MASK_CRNR  = 4'd8;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_LEFT   = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_BOTTOM = 2'd3
    } t_edge;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic               has_child;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] neighbor_index;
        logic              available;
        logic              crosses_face;
        logic [FACE_W-1:0] neighbor_face;
        logic [POS_W-1:0]  neighbor_x;
        logic [POS_W-1:0]  neighbor_y;
        logic [MASK_W-1:0] sub_mask;
        logic              last;
    } t_out_item;

    // Adjacent face across one edge
    function automatic logic [FACE_W-1:0] fold_face(input logic [FACE_W-1:0] face,
                                                   input t_edge edge_sel);
        logic [FACE_W-1:0] res;
        res = FACE_BACK;
        case (face)
            3'd0: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd4;
                    EDGE_LEFT:   res = 3'd3;
                    EDGE_RIGHT:  res = 3'd2;
                    default:     res = 3'd5;
                endcase
            end
            3'd1: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd4;
                    EDGE_LEFT:   res = 3'd2;
                    EDGE_RIGHT:  res = 3'd3;
                    default:     res = 3'd5;
                endcase
            end
            3'd2: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd0;
                    EDGE_LEFT:   res = 3'd5;
                    EDGE_RIGHT:  res = 3'd4;
                    default:     res = 3'd1;
                endcase
            end
            3'd3: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd0;
                    EDGE_LEFT:   res = 3'd4;
                    EDGE_RIGHT:  res = 3'd5;
                    default:     res = 3'd1;
                endcase
            end
            3'd4: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd2;
                    EDGE_LEFT:   res = 3'd1;
                    EDGE_RIGHT:  res = 3'd0;
                    default:     res = 3'd3;
                endcase
            end
            default: begin
                case (edge_sel)
                    EDGE_TOP:    res = 3'd2;
                    EDGE_LEFT:   res = 3'd0;
                    EDGE_RIGHT:  res = 3'd1;
                    default:     res = 3'd3;
                endcase
            end
        endcase
        return res;
    endfunction

    // Permute quarter bits onto the adjacent face
    function automatic logic [MASK_W-1:0] fold_mask(input logic [MASK_W-1:0] mk,
                                                   input logic second);
        logic [MASK_W-1:0] res;
        if (!second) begin
            res = {mk[1], mk[3], mk[0], mk[2]};
        end else begin
            res = {mk[2], mk[0], mk[3], mk[1]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/cfn_decode.sv
// ============================================================================
// cfn_decode: input item decode
// Clamps face and level, derives tile column/row, edge limit and child quarter.
// ============================================================================
`default_nettype none

module cfn_decode import cfn_pkg::*; #(
    parameter int unsigned COORD_BITS = 20
) (
    input  t_in_item               i_item,
    output logic [FACE_W-1:0]      o_face,
    output logic [COORD_BITS-1:0]  o_cx,
    output logic [COORD_BITS-1:0]  o_cy,
    output logic [COORD_BITS-1:0]  o_m,
    output logic                   o_bu,
    output logic                   o_bv,
    output logic                   o_hc
);
    localparam int unsigned CW = COORD_BITS;
    localparam int unsigned LW = $clog2(COORD_BITS + 1);

    logic [LW-1:0] lev;
    logic [LW-1:0] sh;
    logic [LW-1:0] sh_m1;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;

    assign o_face = (i_item.face > FACE_BACK) ? FACE_BACK : i_item.face;
    assign lev    = (32'(i_item.level) > COORD_BITS) ? LW'(COORD_BITS) : LW'(i_item.level);
    assign sh     = LW'(COORD_BITS) - lev;
    assign sh_m1  = sh - LW'(1);
    assign px     = CW'(i_item.pos_x);
    assign py     = CW'(i_item.pos_y);
    assign o_cx   = px >> sh;
    assign o_cy   = py >> sh;
    assign o_m    = ~({CW{1'b1}} << lev);
    assign bx     = px >> sh_m1;
    assign by     = py >> sh_m1;
    // finest level has no child quarter below it
    assign o_bu   = (sh != '0) && bx[0];
    assign o_bv   = (sh != '0) && by[0];
    assign o_hc   = i_item.has_child;

endmodule

`default_nettype wire

### sv/cfn_slot.sv
// ============================================================================
// cfn_slot: one neighbor slot
// Edge tests, face fold of coordinates and quarter mask for the chosen slot.
// ============================================================================
`default_nettype none

module cfn_slot import cfn_pkg::*; #(
    parameter int unsigned COORD_BITS = 20
) (
    input  logic [SLOT_W-1:0]      i_slot,
    input  logic [FACE_W-1:0]      i_face,
    input  logic [COORD_BITS-1:0]  i_cx,
    input  logic [COORD_BITS-1:0]  i_cy,
    input  logic [COORD_BITS-1:0]  i_m,
    input  logic                   i_bu,
    input  logic                   i_bv,
    input  logic                   i_hc,
    output t_out_item              o_result
);
    localparam int unsigned CW = COORD_BITS;

    logic [1:0]        u;
    logic [1:0]        v;
    logic              lo_x, hi_x, lo_y, hi_y;
    logic              offu, offv, diff, avail;
    logic              ox, oy;
    logic [1:0]        u_c, v_c;
    logic              is_su, is_sv, is_sc;
    logic [MASK_W-1:0] mask;
    logic [CW-1:0]     tx, ty, nx, ny;
    t_edge             edge_sel;
    logic [FACE_W-1:0] nface;

    // slot to column/row
    always_comb begin
        unique case (i_slot)
            4'd0: begin u = COL_LEFT;  v = ROW_BOTTOM; end
            4'd1: begin u = COL_MID;   v = ROW_BOTTOM; end
            4'd2: begin u = COL_RIGHT; v = ROW_BOTTOM; end
            4'd3: begin u = COL_LEFT;  v = ROW_MID;    end
            4'd4: begin u = COL_MID;   v = ROW_MID;    end
            4'd5: begin u = COL_RIGHT; v = ROW_MID;    end
            4'd6: begin u = COL_LEFT;  v = ROW_TOP;    end
            4'd7: begin u = COL_MID;   v = ROW_TOP;    end
            4'd8: begin u = COL_RIGHT; v = ROW_TOP;    end
            default: begin u = COL_MID; v = ROW_MID; end
        endcase
    end

    assign lo_x  = (i_cx == '0);
    assign hi_x  = (i_cx == i_m);
    assign lo_y  = (i_cy == '0);
    assign hi_y  = (i_cy == i_m);
    assign offu  = ((u == COL_LEFT) && lo_x) || ((u == COL_RIGHT) && hi_x);
    assign offv  = ((v == ROW_BOTTOM) && lo_y) || ((v == ROW_TOP) && hi_y);
    assign diff  = offu || offv;
    assign avail = !(offu && offv);

    // child quarter slots: side, vertical and corner neighbors next to the child
    assign u_c   = i_bu ? COL_RIGHT : COL_LEFT;
    assign v_c   = i_bv ? ROW_TOP : ROW_BOTTOM;
    assign ox    = i_bu ? hi_x : lo_x;
    assign oy    = i_bv ? hi_y : lo_y;
    assign is_su = (u == u_c) && (v == ROW_MID);
    assign is_sv = (u == COL_MID) && (v == v_c);
    assign is_sc = (u == u_c) && (v == v_c);

    always_comb begin
        mask = MASK_FULL;
        if (i_hc) begin
            if (i_slot == CENTER_SLOT) begin
                mask = MASK_NONE;
            end else if (is_su) begin
                mask = ~(MASK_SIDE >> i_bu);
                if (ox) begin
                    mask = fold_mask(mask, i_bu ^ i_face[0]);
                end
            end else if (is_sv) begin
                mask = ~(MASK_VERT >> {i_bv, 1'b0});
                if (oy) begin
                    mask = fold_mask(mask, i_face[0]);
                end
            end else if (is_sc) begin
                mask = ~(MASK_CRNR >> {i_bv, i_bu});
                // fold across the one edge crossed; a double crossing is unavailable
                if (ox && !oy) begin
                    mask = fold_mask(mask, i_bu ^ i_face[0]);
                end else if (oy && !ox) begin
                    mask = fold_mask(mask, i_face[0]);
                end
            end
        end
    end

    // tile before folding
    always_comb begin
        tx = i_cx;
        ty = i_cy;
        if (!offu) begin
            case (u)
                COL_LEFT:  tx = i_cx - CW'(1);
                COL_RIGHT: tx = i_cx + CW'(1);
                default:   tx = i_cx;
            endcase
        end
        if (!offv) begin
            case (v)
                ROW_BOTTOM: ty = i_cy - CW'(1);
                ROW_TOP:    ty = i_cy + CW'(1);
                default:    ty = i_cy;
            endcase
        end
    end

    always_comb begin
        if (offv) begin
            edge_sel = (v == ROW_BOTTOM) ? EDGE_BOTTOM : EDGE_TOP;
        end else begin
            edge_sel = (u == COL_LEFT) ? EDGE_LEFT : EDGE_RIGHT;
        end
    end

    // fold onto the adjacent face
    always_comb begin
        nx    = tx;
        ny    = ty;
        nface = i_face;
        if (diff) begin
            nface = fold_face(i_face, edge_sel);
            if (!i_face[0]) begin
                unique case (edge_sel)
                    EDGE_TOP:    begin nx = i_m;        ny = tx;  end
                    EDGE_LEFT:   begin nx = i_m - ty;   ny = i_m; end
                    EDGE_RIGHT:  begin nx = ty;         ny = i_m; end
                    EDGE_BOTTOM: begin nx = '0;         ny = tx;  end
                    default:     begin nx = tx;         ny = ty;  end
                endcase
            end else begin
                unique case (edge_sel)
                    EDGE_TOP:    begin nx = '0;         ny = i_m - tx; end
                    EDGE_LEFT:   begin nx = ty;         ny = '0;       end
                    EDGE_RIGHT:  begin nx = i_m - ty;   ny = '0;       end
                    EDGE_BOTTOM: begin nx = i_m;        ny = i_m - tx; end
                    default:     begin nx = tx;         ny = ty;       end
                endcase
            end
        end
    end

    always_comb begin
        o_result                = '0;
        o_result.neighbor_index = i_slot;
        o_result.last           = (i_slot == LAST_SLOT);
        if (avail) begin
            o_result.available     = 1'b1;
            o_result.crosses_face  = diff;
            o_result.neighbor_face = nface;
            o_result.neighbor_x    = POS_W'(nx);
            o_result.neighbor_y    = POS_W'(ny);
            o_result.sub_mask      = mask;
        end
    end

endmodule

`default_nettype wire

### sv/cube_face_tile_neighbor_finder_core.sv
// ============================================================================
// cube_face_tile_neighbor_finder_core: cube face quadtree neighbor finder
// Takes a face, level and position; emits the nine 3x3 neighbor tiles of the
// tile at that level, folded across face edges, with quarter masks.
// ============================================================================
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -----------------------
//  in        sink       i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       source     o_out_valid / i_out_ready  o_out_item (t_out_item)
//
//  Each item yields nine result items, slots 0 to 8, one per cycle while the
//  output does not stall; the slot counter over the one result register sets
//  that rate. The first result of an item passes the decoded item registers,
//  then the result register; the next item is taken together with the last
//  slot of the current one, so a steady stream runs without gaps.
//  Stalls on the output hold the result register and the slot counter.
//  Reset (synchronous, active low) clears busy, the slot counter and output
//  valid only.
//
`default_nettype none

module cube_face_tile_neighbor_finder_core import cfn_pkg::*; #(
    parameter int unsigned COORD_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    localparam int unsigned CW = COORD_BITS;

    // decoded item, held while its nine slots go out
    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    logic [FACE_W-1:0] r_face;
    logic [CW-1:0]     r_cx, r_cy, r_m;
    logic              r_bu, r_bv, r_hc;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [FACE_W-1:0] n_face;
    logic [CW-1:0]     n_cx, n_cy, n_m;
    logic              n_bu, n_bv, n_hc;
    t_out_item         n_out;

    logic              out_adv;
    logic              in_acc;
    logic              slot_last;

    cfn_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_decode (
        .i_item (i_in_item),
        .o_face (n_face),
        .o_cx   (n_cx),
        .o_cy   (n_cy),
        .o_m    (n_m),
        .o_bu   (n_bu),
        .o_bv   (n_bv),
        .o_hc   (n_hc)
    );

    cfn_slot #(
        .COORD_BITS (COORD_BITS)
    ) u_slot (
        .i_slot   (r_slot),
        .i_face   (r_face),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_m      (r_m),
        .i_bu     (r_bu),
        .i_bv     (r_bv),
        .i_hc     (r_hc),
        .o_result (n_out)
    );

    // the result register moves when empty or drained this cycle
    assign out_adv    = !r_out_valid || i_out_ready;
    assign slot_last  = (r_slot == LAST_SLOT);
    // take a new item when idle, or as the last slot leaves
    assign o_in_ready = !r_busy || (slot_last && out_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // control: busy flag, slot counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= FIRST_SLOT;
            r_out_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_busy;
            end
            if (in_acc) begin
                // a new item restarts the slot walk
                r_busy <= 1'b1;
                r_slot <= FIRST_SLOT;
            end else if (out_adv && r_busy) begin
                // advance through the slots; drop busy after the last one
                r_slot <= r_slot + SLOT_W'(1);
                if (slot_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // payload: decoded item and result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_face <= n_face;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_m    <= n_m;
            r_bu   <= n_bu;
            r_bv   <= n_bv;
            r_hc   <= n_hc;
        end
        if (out_adv && r_busy) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a taken item starts at the first slot
    a_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_busy && (r_slot == FIRST_SLOT)))
        else $error("slot counter not restarted on new item");

    // slot counter stays inside the block while busy
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slot <= LAST_SLOT))
        else $error("slot counter out of range");

    // last flag marks the final slot
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (o_out_item.neighbor_index == LAST_SLOT))
        else $error("last flag on wrong slot");

    // an unavailable neighbor carries nothing
    a_unavail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.available) |->
            ((o_out_item.sub_mask == MASK_NONE) && !o_out_item.crosses_face))
        else $error("unavailable neighbor carries data");

    // the tile itself is always on its own face
    a_center_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.neighbor_index == CENTER_SLOT)) |->
            (o_out_item.available && !o_out_item.crosses_face))
        else $error("center slot folded or unavailable");

endmodule

`default_nettype wire

### dv/cube_face_tile_neighbor_finder_core_test.sv
// ============================================================================
// cube_face_tile_neighbor_finder_core_test: neighbor finder testbench
// Drives query items through the valid/ready input channel and checks each
// of the nine neighbor result items against a local neighbor predictor.
// A directed table opens the run, followed by random queries biased toward
// face edges and corners, under three sender/receiver idle mixes.
// ============================================================================
`default_nettype none

module cube_face_tile_neighbor_finder_core_test;
    import cfn_pkg::*;

    localparam int unsigned COORD_BITS  = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned RANDOM_PER_PHASE = 84;

    // Edge-crossing slots of the 3x3 block, u + 3v
    localparam int unsigned NB_BOTTOM = 1;
    localparam int unsigned NB_LEFT   = 3;
    localparam int unsigned NB_RIGHT  = 5;
    localparam int unsigned NB_TOP    = 7;

    // One directed query; a typed row carries one hand-written neighbor
    // item that replaces the predicted one for its slot.
    typedef struct packed {
        t_in_item  query;
        logic      typed;
        t_out_item typed_res;
    } t_stim_row;

    localparam t_stim_row DIRECTED_PLAN [20] = '{
        // level 0: whole face is one tile, corner slots fall off a face edge in both u and v
        '{'{3'd0, 5'd0, 20'h00000, 20'h00000, 1'b0}, 1'b1,
          '{4'd0, 1'b0, 1'b0, 3'd0, 20'h00000, 20'h00000, 4'd0, 1'b0}},
        // face 7 folds to back face
        '{'{3'd7, 5'd0, 20'hFFFFF, 20'hFFFFF, 1'b0}, 1'b1,
          '{CENTER_SLOT, 1'b1, 1'b0, FACE_BACK, 20'h00000, 20'h00000, MASK_FULL, 1'b0}},
        // finest level, top-right tile
        '{'{3'd3, 5'd20, 20'hFFFFF, 20'hFFFFF, 1'b0}, 1'b1,
          '{CENTER_SLOT, 1'b1, 1'b0, 3'd3, 20'hFFFFF, 20'hFFFFF, MASK_FULL, 1'b0}},
        // level above range clamps to finest; child hides the whole center
        '{'{3'd1, 5'd31, 20'h00000, 20'h00000, 1'b1}, 1'b1,
          '{CENTER_SLOT, 1'b1, 1'b0, 3'd1, 20'h00000, 20'h00000, MASK_NONE, 1'b0}},
        // top-left corner at the finest level is off both the left and the top face edge
        '{'{3'd6, 5'd20, 20'h00000, 20'hFFFFF, 1'b0}, 1'b1,
          '{4'd6, 1'b0, 1'b0, 3'd0, 20'h00000, 20'h00000, 4'd0, 1'b0}},
        // inner diagonal of the bottom-left tile, flagged as last
        '{'{3'd2, 5'd2, 20'h00000, 20'h00000, 1'b1}, 1'b1,
          '{LAST_SLOT, 1'b1, 1'b0, 3'd2, 20'h00001, 20'h00001, MASK_FULL, 1'b1}},
        // left edge, one row up: corner mask folds across the left edge
        '{'{3'd0, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        '{'{3'd1, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        '{'{3'd2, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        '{'{3'd3, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        '{'{3'd4, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        '{'{3'd5, 5'd2, 20'h00000, 20'h40000, 1'b1}, 1'b0, '0},
        // right edge, top row inside: upper child quarters
        '{'{3'd1, 5'd3, 20'hFFFFF, 20'h7FFFF, 1'b1}, 1'b0, '0},
        '{'{3'd4, 5'd3, 20'hFFFFF, 20'h7FFFF, 1'b1}, 1'b0, '0},
        // bottom edge on an odd face
        '{'{3'd5, 5'd1, 20'h80000, 20'h00000, 1'b1}, 1'b0, '0},
        '{'{3'd0, 5'd21, 20'h12345, 20'hABCDE, 1'b1}, 1'b0, '0},
        '{'{3'd2, 5'd19, 20'h55555, 20'hFFFFF, 1'b1}, 1'b0, '0},
        '{'{3'd3, 5'd10, 20'hAAAAA, 20'h55555, 1'b0}, 1'b0, '0},
        // top-right corner tile with upper-right child: diagonal lost
        '{'{3'd4, 5'd1, 20'hFFFFF, 20'hFFFFF, 1'b1}, 1'b0, '0},
        // level 0 with child: quarter bits come from the top position bit
        '{'{3'd2, 5'd0, 20'h80000, 20'h00000, 1'b1}, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        query_valid = 1'b0;
    logic        query_ready;
    t_in_item    query = '0;
    logic        nb_valid;
    logic        nb_ready = 1'b0;
    t_out_item   nb_item;

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    t_out_item   pending_neighbors [$];

    cube_face_tile_neighbor_finder_core #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (query_valid),
        .o_in_ready  (query_ready),
        .i_in_item   (query),
        .o_out_valid (nb_valid),
        .i_out_ready (nb_ready),
        .o_out_item  (nb_item)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Permute quarter enables onto the neighboring face; flip picks the
    // second of the two orientations.
    function automatic logic [3:0] turn_quarters(input logic [3:0] q, input logic flip);
        logic [3:0] r;
        if (!flip) begin
            r[0] = q[2];
            r[1] = q[0];
            r[2] = q[3];
            r[3] = q[1];
        end else begin
            r[0] = q[1];
            r[1] = q[3];
            r[2] = q[0];
            r[3] = q[2];
        end
        return r;
    endfunction

    // Work out the nine neighbor items of one query and queue them.
    function automatic void predict_neighbors(input t_in_item q);
        logic [2:0]      fc;
        int unsigned     lvl, sh, su, sv, sc;
        longint unsigned cx, cy, m, tx, ty, nx, ny;
        logic            bu, bv;
        logic [1:0]      u, v;
        logic            off_u [9];
        logic            off_v [9];
        logic            crosses [9];
        logic            open_s [9];
        logic [3:0]      quarters [9];
        logic [11:0]     across_row;
        t_edge           side;
        t_out_item       r;

        fc  = (q.face > FACE_BACK) ? FACE_BACK : q.face;
        lvl = (q.level > COORD_BITS) ? COORD_BITS : int'(q.level);
        sh  = COORD_BITS - lvl;
        cx  = 64'(q.pos_x) >> sh;
        cy  = 64'(q.pos_y) >> sh;
        m   = (64'd1 << lvl) - 1;
        bu  = 1'b0;
        bv  = 1'b0;
        if (sh > 0) begin
            bu = q.pos_x[sh - 1];
            bv = q.pos_y[sh - 1];
        end

        for (int s = 0; s < 9; s++) begin
            u = 2'(s % 3);
            v = 2'(s / 3);
            off_u[s] = (u == COL_LEFT && cx == 0) || (u == COL_RIGHT && cx == m);
            off_v[s] = (v == ROW_BOTTOM && cy == 0) || (v == ROW_TOP && cy == m);
            crosses[s] = off_u[s] || off_v[s];
            open_s[s] = !(off_u[s] && off_v[s]);
            quarters[s] = MASK_FULL;
        end

        // Hide the quarters that the child tile's siblings cover
        if (q.has_child) begin
            su = bu ? NB_RIGHT : NB_LEFT;
            sv = bv ? NB_TOP : NB_BOTTOM;
            sc = 2 * int'(bu) + 6 * int'(bv);
            quarters[su] = ~(MASK_SIDE >> bu);
            quarters[sv] = ~(MASK_VERT >> (2 * int'(bv)));
            quarters[sc] = ~(MASK_CRNR >> (int'(bu) + 2 * int'(bv)));
            quarters[CENTER_SLOT] = MASK_NONE;
            if (crosses[su]) quarters[su] = turn_quarters(quarters[su], (su == NB_RIGHT) ^ fc[0]);
            if (crosses[sv]) quarters[sv] = turn_quarters(quarters[sv], fc[0]);
            if (crosses[sc] && open_s[sc]) begin
                if (crosses[su])
                    quarters[sc] = turn_quarters(quarters[sc], (su == NB_RIGHT) ^ fc[0]);
                if (crosses[sv])
                    quarters[sc] = turn_quarters(quarters[sc], fc[0]);
            end
        end

        // Faces across {top, left, right, bottom}
        case (fc)
            3'd0:    across_row = {3'd4, 3'd3, 3'd2, 3'd5};
            3'd1:    across_row = {3'd4, 3'd2, 3'd3, 3'd5};
            3'd2:    across_row = {3'd0, 3'd5, 3'd4, 3'd1};
            3'd3:    across_row = {3'd0, 3'd4, 3'd5, 3'd1};
            3'd4:    across_row = {3'd2, 3'd1, 3'd0, 3'd3};
            default: across_row = {3'd2, 3'd0, 3'd1, 3'd3};
        endcase

        for (int s = 0; s < 9; s++) begin
            r = '0;
            r.neighbor_index = 4'(s);
            r.last = (s == LAST_SLOT);
            if (open_s[s]) begin
                u  = 2'(s % 3);
                v  = 2'(s / 3);
                tx = off_u[s] ? cx : cx + u - 1;
                ty = off_v[s] ? cy : cy + v - 1;
                nx = tx;
                ny = ty;
                r.neighbor_face = fc;
                if (crosses[s]) begin
                    if (off_v[s]) side = (v == ROW_BOTTOM) ? EDGE_BOTTOM : EDGE_TOP;
                    else side = (u == COL_LEFT) ? EDGE_LEFT : EDGE_RIGHT;
                    r.neighbor_face = across_row[(3 - int'(side)) * 3 +: 3];
                    // Map the coordinates onto the neighboring face's frame
                    case (side)
                        EDGE_TOP: begin
                            nx = fc[0] ? 0 : m;
                            ny = fc[0] ? m - tx : tx;
                        end
                        EDGE_LEFT: begin
                            nx = fc[0] ? ty : m - ty;
                            ny = fc[0] ? 0 : m;
                        end
                        EDGE_RIGHT: begin
                            nx = fc[0] ? m - ty : ty;
                            ny = fc[0] ? 0 : m;
                        end
                        default: begin
                            nx = fc[0] ? m : 0;
                            ny = fc[0] ? m - tx : tx;
                        end
                    endcase
                end
                r.available    = 1'b1;
                r.crosses_face = crosses[s];
                r.neighbor_x   = nx[19:0];
                r.neighbor_y   = ny[19:0];
                r.sub_mask     = quarters[s];
            end
            pending_neighbors.push_back(r);
        end
    endfunction

    // Offer one query after a random gap, hold it until taken, then queue
    // its neighbors.
    task automatic push_query(input t_in_item q, input logic typed, input t_out_item typed_res);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            query_valid <= 1'b0;
            @(negedge clk);
        end
        query <= q;
        query_valid <= 1'b1;
        @(posedge clk);
        while (!query_ready) @(posedge clk);
        predict_neighbors(q);
        if (typed) begin
            pending_neighbors[pending_neighbors.size() - 9 + typed_res.neighbor_index] =
                typed_res;
        end
    endtask

    // Random queries, mostly small levels, tiles pushed onto edges and corners
    task automatic send_random_queries(input int unsigned count);
        t_in_item    q;
        int unsigned pick, lvl, eff;
        logic [19:0] tile_bits;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) lvl = $urandom_range(31, 21);
            else if (pick < 15) lvl = 0;
            else if (pick < 20) lvl = COORD_BITS;
            else if (pick < 75) lvl = $urandom_range(6, 1);
            else lvl = $urandom_range(19, 7);
            q.face = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
            q.level = 5'(lvl);
            q.pos_x = 20'($urandom);
            q.pos_y = 20'($urandom);
            q.has_child = ($urandom_range(9) < 7);
            eff = (lvl > COORD_BITS) ? COORD_BITS : lvl;
            tile_bits = 20'(32'hFFFFF & ~((32'd1 << (COORD_BITS - eff)) - 1));
            pick = $urandom_range(3);
            if (pick == 0) q.pos_x = q.pos_x & ~tile_bits;
            if (pick == 1) q.pos_x = q.pos_x | tile_bits;
            pick = $urandom_range(3);
            if (pick == 0) q.pos_y = q.pos_y & ~tile_bits;
            if (pick == 1) q.pos_y = q.pos_y | tile_bits;
            push_query(q, 1'b0, '0);
        end
    endtask

    // Drop valid and hold until every queued neighbor has come out
    task automatic hold_until_drained();
        @(negedge clk);
        query_valid <= 1'b0;
        while (pending_neighbors.size() != 0) @(negedge clk);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: stall at random per the current mix
    always @(negedge clk) begin
        nb_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted neighbor item against the oldest expectation
    always @(posedge clk) begin : neighbor_check
        t_out_item want;
        if (rst_n && nb_valid && nb_ready) begin
            if (pending_neighbors.size() == 0) begin
                $display("%0t: unexpected neighbor item, expected none, actual %h",
                         $time, nb_item);
                mismatch_count++;
            end else begin
                want = pending_neighbors.pop_front();
                check_field("neighbor_index", want.neighbor_index, nb_item.neighbor_index);
                check_field("available", want.available, nb_item.available);
                check_field("crosses_face", want.crosses_face, nb_item.crosses_face);
                check_field("neighbor_face", want.neighbor_face, nb_item.neighbor_face);
                check_field("neighbor_x", want.neighbor_x, nb_item.neighbor_x);
                check_field("neighbor_y", want.neighbor_y, nb_item.neighbor_y);
                check_field("sub_mask", want.sub_mask, nb_item.sub_mask);
                check_field("last", want.last, nb_item.last);
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d neighbor items still pending", $time,
                 pending_neighbors.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        // Hold reset from the start, release at a falling edge
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Phase 1: slow receiver, sender idles a third of the time
        send_gap_pct = 34;
        recv_stall_pct = 65;
        foreach (DIRECTED_PLAN[k]) begin
            push_query(DIRECTED_PLAN[k].query, DIRECTED_PLAN[k].typed,
                       DIRECTED_PLAN[k].typed_res);
        end
        send_random_queries(RANDOM_PER_PHASE / 2);
        // Pause the sender until the block has fully drained
        hold_until_drained();
        send_random_queries(RANDOM_PER_PHASE / 2);
        hold_until_drained();

        // Phase 2: slow sender, receiver stalls a third of the time
        send_gap_pct = 65;
        recv_stall_pct = 34;
        send_random_queries(RANDOM_PER_PHASE);
        hold_until_drained();

        // Phase 3: back to back in both directions
        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_random_queries(RANDOM_PER_PHASE);
        hold_until_drained();

        // Give stray items a chance to show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
